// File: hw/rtl/sgcd_pkg.sv
// sgcd_pkg: shared types for the shifted-set gcd engine
// controller state, controller-to-datapath commands and datapath status
// no dependencies
package sgcd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SHIFT
    } sgcd_state_t;

    typedef struct packed {
        logic accept;  // take a new word from the input ports
        logic run;     // one binary gcd step
        logic shift;   // restore common power of two, finish when count is zero
    } sgcd_cmd_t;

    typedef struct packed {
        logic direct;  // input word is a load that starts a set or hits an empty set, no gcd needed
        logic gcd_zero; // one gcd operand reached zero
        logic k_zero;  // power-of-two count exhausted
    } sgcd_status_t;

endpackage

// File: hw/rtl/sgcd_ctrl.sv
// sgcd_ctrl: controller state machine of the shifted-set gcd engine
// sequences accept, gcd steps and the final shift-back
// depends on sgcd_pkg
module sgcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sgcd_pkg::sgcd_status_t status,
    output sgcd_pkg::sgcd_cmd_t    cmd,
    output logic                  busy
);
    import sgcd_pkg::*;

    sgcd_state_t state_reg;
    sgcd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (!status.direct)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (status.gcd_zero)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.k_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sgcd_datapath.sv
// sgcd_datapath: set state, binary gcd operand registers and result register
// driven by the commands of sgcd_ctrl
// depends on sgcd_pkg
module sgcd_datapath #(
    parameter int DATA_WIDTH = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sgcd_pkg::sgcd_cmd_t     cmd,
    output sgcd_pkg::sgcd_status_t  status,
    input  logic                    func,
    input  logic                    start_set,
    input  logic [DATA_WIDTH-1:0]   operand,
    output logic                    result_valid,
    output logic [DATA_WIDTH:0]     gcd_result
);
    import sgcd_pkg::*;

    localparam int SW = DATA_WIDTH + 1;
    localparam int KW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] first_reg;
    logic [DATA_WIDTH-1:0] dgcd_reg;
    logic [1:0]            size_reg;
    logic                  func_reg;
    logic [SW-1:0]         a_reg;
    logic [SW-1:0]         b_reg;
    logic [KW-1:0]         k_reg;
    logic                  valid_reg;
    logic [SW-1:0]         result_reg;

    logic [DATA_WIDTH-1:0] diff;
    logic [SW-1:0]         sum;
    logic                  a_ge_b;
    logic                  finish;

    assign diff   = (operand >= first_reg) ? (operand - first_reg) : (first_reg - operand);
    assign sum    = {1'b0, first_reg} + {1'b0, operand};
    assign a_ge_b = (a_reg >= b_reg);
    assign finish = cmd.shift && (k_reg == '0);

    assign status.direct   = !func && (start_set || (size_reg == 2'd0));
    assign status.gcd_zero = (a_reg == '0) || (b_reg == '0);
    assign status.k_zero   = (k_reg == '0);

    // set state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            dgcd_reg  <= '0;
            size_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= finish && func_reg;
            if (cmd.accept && !func)
            begin
                if (status.direct)
                begin
                    first_reg <= operand;
                    dgcd_reg  <= '0;
                    size_reg  <= 2'd1;
                end
                else
                begin
                    size_reg <= 2'd2;
                end
            end
            if (finish && !func_reg)
            begin
                dgcd_reg <= a_reg[DATA_WIDTH-1:0];
            end
        end
    end

    // binary gcd operands
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            k_reg    <= '0;
            if (func)
            begin
                a_reg <= sum;
                b_reg <= (size_reg == 2'd2) ? {1'b0, dgcd_reg} : '0;
            end
            else
            begin
                a_reg <= {1'b0, dgcd_reg};
                b_reg <= {1'b0, diff};
            end
        end
        else if (cmd.run)
        begin
            priority if (status.gcd_zero)
            begin
                a_reg <= a_reg | b_reg;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_reg <= (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
        else if (cmd.shift && !status.k_zero)
        begin
            // put back the common power of two one bit at a time
            a_reg <= a_reg << 1;
            k_reg <= k_reg - KW'(1);
        end
        if (finish)
        begin
            result_reg <= a_reg;
        end
    end

    assign result_valid = valid_reg;
    assign gcd_result   = result_reg;

endmodule

// File: hw/rtl/shifted_set_gcd_engine_core.sv
// shifted_set_gcd_engine_core: top level of the shifted-set gcd engine
// instantiates sgcd_ctrl and sgcd_datapath; depends on sgcd_pkg
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   input    | start, busy            | func, start_set, operand
//   result   | result_valid (strobe)  | gcd_result
//
// a load that starts a set (or hits an empty set) completes at accept, the engine stays idle
// other loads and all queries: an accept step, then binary gcd steps in the
// shared subtract/shift unit, then a shift-back step for each common factor of
// two and a final step; the result strobe of a query is registered from the final step
// reset clears the set to empty; results cannot be stalled and last one cycle
module shifted_set_gcd_engine_core #(
    parameter int DATA_WIDTH = 60
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic                  start_set,
    input  logic [DATA_WIDTH-1:0] operand,
    output logic                  result_valid,
    output logic [DATA_WIDTH:0]   gcd_result
);
    import sgcd_pkg::*;

    sgcd_cmd_t    cmd;
    sgcd_status_t status;

    sgcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sgcd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (func),
        .start_set    (start_set),
        .operand      (operand),
        .result_valid (result_valid),
        .gcd_result   (gcd_result)
    );

endmodule

// File: hw/rtl/sgcd_checker.sv
// sgcd_checker: port-level assertions for shifted_set_gcd_engine_core
// bound to the top level below; no package dependency
module sgcd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic func,
    input logic start_set,
    input logic result_valid
);

    // a result always closes a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding busy period");

    // a query always goes through the gcd unit
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func) |=> busy)
        else $error("query accepted but engine not busy");

    // starting a new set is a load that leaves the engine idle
    a_new_set_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func && start_set) |=> !busy)
        else $error("new-set load did not complete in one cycle");

    // results are single strobes, never back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind shifted_set_gcd_engine_core sgcd_checker u_sgcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .start_set    (start_set),
    .result_valid (result_valid)
);

// File: tb/shifted_set_gcd_engine_core_tb.sv
// shifted_set_gcd_engine_core_tb: self-checking testbench for the shifted-set gcd engine
// directed table plus random load/query words; query results vs predictor or typed-in value
// depends on shifted_set_gcd_engine_core (and through it sgcd_pkg)
module shifted_set_gcd_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};
    localparam logic [DW:0] TWICE_ONES = {1'b0, ALL_ONES} << 1;

    typedef enum logic [1:0] {
        CLASS_EMPTY,
        CLASS_ONE,
        CLASS_MANY
    } set_class_t;

    typedef struct {
        logic          f;
        logic          s;
        logic [DW-1:0] op;
        bit            has_ref;
        logic [DW:0]   ref_val;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          func;
    logic          start_set;
    logic [DW-1:0] operand;
    logic          result_valid;
    logic [DW:0]   gcd_result;

    // typed-in expectation travelling with the word being offered
    bit            row_has_ref;
    logic [DW:0]   row_ref_value;

    // predictor state
    logic [DW-1:0] first_elem = '0;
    logic [DW-1:0] diff_gcd = '0;
    set_class_t    set_class = CLASS_EMPTY;

    logic [DW:0]   gcd_expect_q[$];
    int            err_count = 0;
    int            cycle_count = 0;
    int            idle_pct = 0;

    shifted_set_gcd_engine_core #(
        .DATA_WIDTH(DW)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .start_set   (start_set),
        .operand     (operand),
        .result_valid(result_valid),
        .gcd_result  (gcd_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [DW:0] euclid_gcd(input logic [DW:0] a, input logic [DW:0] b);
        logic [DW:0] r;
        while (b != '0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic void predict_word(input logic f, input logic s, input logic [DW-1:0] op,
                                         output bit has_res, output logic [DW:0] res);
        logic [DW-1:0] diff;
        logic [DW:0]   g;
        logic [DW:0]   sum;
        has_res = 1'b0;
        res = '0;
        if (f == FUNC_LOAD)
        begin
            if (s || set_class == CLASS_EMPTY)
            begin
                first_elem = op;
                diff_gcd = '0;
                set_class = CLASS_ONE;
            end
            else
            begin
                diff = (op >= first_elem) ? op - first_elem : first_elem - op;
                g = euclid_gcd({1'b0, diff_gcd}, {1'b0, diff});
                diff_gcd = g[DW-1:0];
                set_class = CLASS_MANY;
            end
        end
        else
        begin
            sum = {1'b0, first_elem} + {1'b0, op};
            res = (set_class == CLASS_MANY) ? euclid_gcd(sum, {1'b0, diff_gcd}) : sum;
            has_res = 1'b1;
        end
    endfunction

    // accepted words feed the predictor; strobed results are checked in order
    always @(posedge clk)
    begin : monitor
        bit          has_res;
        logic [DW:0] res;
        logic [DW:0] exp_val;
        logic [DW:0] new_exp;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_word(func, start_set, operand, has_res, res);
                if (has_res)
                begin
                    new_exp = row_has_ref ? row_ref_value : res;
                    gcd_expect_q = {gcd_expect_q, new_exp};
                end
            end
            if (result_valid)
            begin
                if (gcd_expect_q.size() == 0)
                begin
                    $error("unexpected result word, gcd_result %0d", gcd_result);
                    err_count++;
                end
                else
                begin
                    exp_val = gcd_expect_q.pop_front();
                    if (gcd_result !== exp_val)
                    begin
                        $error("gcd_result mismatch: expected %0d, actual %0d",
                               exp_val, gcd_result);
                        err_count++;
                    end
                end
            end
        end
    end

    function automatic logic [DW-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] pick_operand();
        logic [DW-1:0] w;
        w = rand_word();
        unique case ($urandom_range(0, 5))
            0: return w;
            1: return DW'($urandom_range(0, 255));
            2: return ALL_ONES;
            3: return DW'(1) << $urandom_range(0, DW - 1);
            4: return w >> $urandom_range(1, DW - 1);
            default: return '0;
        endcase
    endfunction

    task automatic send_word(input logic f, input logic s, input logic [DW-1:0] op,
                             input bit has_ref, input logic [DW:0] ref_val);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        func <= f;
        start_set <= s;
        operand <= op;
        row_has_ref <= has_ref;
        row_ref_value <= ref_val;
        do
            @(posedge clk);
        while (busy);
    endtask

    // mostly well-formed sets whose elements share a common step, plus noise words
    task automatic run_random(input int n_words, input int pct);
        int          sent;
        int          n_loads;
        int          n_queries;
        logic [63:0] step;
        logic [63:0] base;
        logic [DW-1:0] offs;
        sent = 0;
        idle_pct = pct;
        while (sent < n_words)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_operand(),
                          1'b0, '0);
                sent++;
            end
            else
            begin
                step = 64'($urandom_range(1, 4095)) << $urandom_range(0, 30);
                base = {4'h0, rand_word()} >> $urandom_range(1, 40);
                n_loads = $urandom_range(0, 6);
                n_queries = $urandom_range(1, 3);
                send_word(FUNC_LOAD, 1'b1, DW'(base + step * $urandom_range(0, 1000)), 1'b0, '0);
                repeat (n_loads)
                    send_word(FUNC_LOAD, 1'b0, DW'(base + step * $urandom_range(0, 1000)),
                              1'b0, '0);
                repeat (n_queries)
                begin
                    if ($urandom_range(0, 1))
                        offs = DW'(step * $urandom_range(0, 1000));
                    else
                        offs = pick_operand();
                    send_word(FUNC_QUERY, 1'($urandom_range(0, 1)), offs, 1'b0, '0);
                end
                sent += 1 + n_loads + n_queries;
            end
        end
    endtask

    dir_row_t dir_rows[] = '{
        '{FUNC_QUERY, 1'b0, '0, 1'b1, '0},                       // empty set: offset alone
        '{FUNC_QUERY, 1'b1, ALL_ONES, 1'b1, {1'b0, ALL_ONES}},
        '{FUNC_LOAD, 1'b0, 60'd12, 1'b0, '0},                    // load on empty set opens it
        '{FUNC_QUERY, 1'b0, '0, 1'b1, 61'd12},
        '{FUNC_LOAD, 1'b0, 60'd12, 1'b0, '0},                    // zero difference
        '{FUNC_QUERY, 1'b0, '0, 1'b1, 61'd12},
        '{FUNC_LOAD, 1'b1, '0, 1'b0, '0},
        '{FUNC_LOAD, 1'b0, '0, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, '0, 1'b1, '0},                       // zero sum, zero gcd
        '{FUNC_LOAD, 1'b1, ALL_ONES, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, ALL_ONES, 1'b1, TWICE_ONES},         // widest sum
        '{FUNC_LOAD, 1'b0, '0, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, ALL_ONES, 1'b1, {1'b0, ALL_ONES}},
        '{FUNC_QUERY, 1'b0, '0, 1'b1, {1'b0, ALL_ONES}},
        '{FUNC_LOAD, 1'b1, 60'd100, 1'b0, '0},
        '{FUNC_LOAD, 1'b0, 60'd130, 1'b0, '0},
        '{FUNC_LOAD, 1'b0, 60'd70, 1'b0, '0},
        '{FUNC_LOAD, 1'b0, 60'd250, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, 60'd20, 1'b0, '0},
        '{FUNC_QUERY, 1'b1, 60'd5, 1'b0, '0},
        '{FUNC_LOAD, 1'b1, 60'h800_0000_0000_0000, 1'b0, '0},
        '{FUNC_LOAD, 1'b0, '0, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, 60'h800_0000_0000_0000, 1'b0, '0},
        '{FUNC_LOAD, 1'b1, 60'h300_0000_0000, 1'b0, '0},        // many common factors of two
        '{FUNC_LOAD, 1'b0, '0, 1'b0, '0},
        '{FUNC_QUERY, 1'b0, '0, 1'b0, '0}
    };

    initial
    begin
        start = 1'b0;
        func = FUNC_LOAD;
        start_set = 1'b0;
        operand = '0;
        row_has_ref = 1'b0;
        row_ref_value = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 32;
        foreach (dir_rows[i])
            send_word(dir_rows[i].f, dir_rows[i].s, dir_rows[i].op,
                      dir_rows[i].has_ref, dir_rows[i].ref_val);

        run_random(285, 32);
        run_random(285, 52);
        run_random(285, 0);

        @(negedge clk);
        start <= 1'b0;
        while (gcd_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
